// ===== hdl/ebmlenc_pkg.sv =====
// ----------------------------------------------------------------------------
// EBML element header encoder package
// Shared widths, operation codes, queue entry type and byte count helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package ebmlenc_pkg;

	localparam int OpW        = 2;
	localparam int IdW        = 32;
	localparam int ValW       = 64;
	localparam int FszW       = 4;
	localparam int PlenW      = 56;
	localparam int ByteW      = 8;
	localparam int InDataW    = 160;
	localparam int WordBytes  = 13;
	localparam int WordW      = WordBytes * ByteW;
	localparam int BodyW      = 72;
	localparam int CntW       = 4;
	localparam int QueueDepthDef = 2;

	localparam logic [63:0] UnknownSizeMark = 64'h01FF_FFFF_FFFF_FFFF;

	typedef enum logic [OpW-1:0] {
		OP_UINT   = 2'd0,
		OP_DATA   = 2'd1,
		OP_MASTER = 2'd2,
		OP_NONE   = 2'd3
	} op_t;

	// word: element bytes left-aligned, first byte in the top bits
	typedef struct packed {
		logic [WordW-1:0] word;
		logic [CntW-1:0]  total;
	} desc_t;

	typedef struct packed {
		logic [CntW-1:0] rem;
	} back_stat_t;

	function automatic logic [2:0] id_bytes(input logic [IdW-1:0] v);
		logic [2:0] n;
		n = 3'd1;
		for (int i = 1; i < 4; i++) begin
			if (v[8*i +: 8] != 8'h00) n = 3'(i + 1);
		end
		return n;
	endfunction

	function automatic logic [CntW-1:0] min_bytes(input logic [ValW-1:0] v);
		logic [CntW-1:0] n;
		n = 4'd1;
		for (int i = 1; i < 8; i++) begin
			if (v[8*i +: 8] != 8'h00) n = CntW'(i + 1);
		end
		return n;
	endfunction

	function automatic logic [CntW-1:0] vint_len(input logic [PlenW-1:0] len);
		logic [CntW-1:0] n;
		n = 4'd1;
		for (int k = 1; k < 8; k++) begin
			if ((len >> (7 * k)) != '0) n = n + 4'd1;
		end
		return n;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/ebmlenc_front.sv =====
// ----------------------------------------------------------------------------
// EBML encoder front
// Accepts requests, sizes the ID and body, builds one left-aligned byte word.
// ----------------------------------------------------------------------------
`default_nettype none

module ebmlenc_front import ebmlenc_pkg::*; (
	input  wire logic [OpW-1:0]   operation,
	input  wire logic [IdW-1:0]   class_id,
	input  wire logic [ValW-1:0]  value,
	input  wire logic [FszW-1:0]  fixed_size,
	input  wire logic [PlenW-1:0] payload_length,
	input  wire logic             in_valid,
	output logic                  in_ready,
	input  wire logic             q_full,
	output logic                  push,
	output desc_t                 desc
);

	logic [2:0]       id_n;
	logic [IdW-1:0]   id_al;
	logic [CntW-1:0]  usz;
	logic [CntW-1:0]  vsz;
	logic [5:0]       vsh;
	logic [ValW-1:0]  vint;
	logic [BodyW-1:0] body;
	logic [CntW-1:0]  blen;

	assign in_ready = !q_full;
	assign push     = in_valid && !q_full && (op_t'(operation) != OP_NONE);

	always_comb begin
		id_n  = id_bytes(class_id);
		id_al = class_id << 6'(8 * (4 - int'(id_n)));
		if (fixed_size == '0) begin
			usz = min_bytes(value);
		end else if (fixed_size > 4'd8) begin
			usz = 4'd8;
		end else begin
			usz = fixed_size;
		end
		vsz  = vint_len(payload_length);
		vsh  = 6'(7 * int'(vsz));
		vint = ({8'h00, payload_length} & ((64'd1 << vsh) - 64'd1)) | (64'd1 << vsh);
		case (op_t'(operation))
			OP_UINT: begin
				body = {8'h80 | {4'h0, usz}, value << 6'(8 * (8 - int'(usz)))};
				blen = usz + 4'd1;
			end
			OP_DATA: begin
				body = {vint << 6'(8 * (8 - int'(vsz))), 8'h00};
				blen = vsz;
			end
			default: begin
				body = {UnknownSizeMark, 8'h00};
				blen = 4'd8;
			end
		endcase
		desc.word  = {id_al, {BodyW{1'b0}}} | ({body, {IdW{1'b0}}} >> 6'(8 * int'(id_n)));
		desc.total = {1'b0, id_n} + blen;
	end

endmodule

`default_nettype wire

// ===== hdl/ebmlenc_queue.sv =====
// ----------------------------------------------------------------------------
// EBML encoder word queue
// Small register FIFO between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module ebmlenc_queue import ebmlenc_pkg::*; #(
	parameter int Depth = QueueDepthDef
) (
	input  wire logic  clk,
	input  wire logic  arst_n,
	input  wire logic  push,
	input  wire desc_t push_desc,
	output logic       full,
	input  wire logic  pop,
	output logic       empty,
	output desc_t      head,
	output logic [$clog2(Depth+1)-1:0] count
);

	localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
	localparam int CntQW = $clog2(Depth + 1);

	desc_t             mem_q [Depth];
	logic [PtrW-1:0]   wr_ptr_q;
	logic [PtrW-1:0]   rd_ptr_q;
	logic [CntQW-1:0]  cnt_q;

	assign full  = (cnt_q == CntQW'(Depth));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_ptr_q];
	assign count = cnt_q;

	function automatic logic [PtrW-1:0] nxt(input logic [PtrW-1:0] p);
		return (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= nxt(wr_ptr_q);
			if (pop) rd_ptr_q <= nxt(rd_ptr_q);
			if (push && !pop) begin
				cnt_q <= cnt_q + CntQW'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - CntQW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_desc;
	end

endmodule

`default_nettype wire

// ===== hdl/ebmlenc_back.sv =====
// ----------------------------------------------------------------------------
// EBML encoder back
// Shifts queued words out into the output register, one byte per cycle while out_ready does not stall it.
// ----------------------------------------------------------------------------
`default_nettype none

module ebmlenc_back import ebmlenc_pkg::*; (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        q_empty,
	input  wire desc_t       head,
	output logic             pop,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [ByteW-1:0] out_byte,
	output logic             out_last,
	output back_stat_t       stat
);

	logic             valid_q;
	logic [CntW-1:0]  rem_q;
	logic [WordW-1:0] sh_q;
	logic [ByteW-1:0] byte_q;
	logic             last_q;
	logic             slot_free;

	assign slot_free = !valid_q || out_ready;
	assign pop       = slot_free && (rem_q == '0) && !q_empty;
	assign out_valid = valid_q;
	assign out_byte  = byte_q;
	assign out_last  = last_q;
	assign stat.rem  = rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			rem_q   <= '0;
		end else if (slot_free) begin
			if (rem_q != '0) begin
				valid_q <= 1'b1;
				rem_q   <= rem_q - 4'd1;
			end else if (!q_empty) begin
				valid_q <= 1'b1;
				rem_q   <= head.total - 4'd1;
			end else begin
				valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (slot_free) begin
			if (rem_q != '0) begin
				byte_q <= sh_q[WordW-1 -: ByteW];
				last_q <= (rem_q == 4'd1);
				sh_q   <= sh_q << ByteW;
			end else if (!q_empty) begin
				byte_q <= head.word[WordW-1 -: ByteW];
				last_q <= (head.total == 4'd1);
				sh_q   <= head.word << ByteW;
			end
		end
	end

endmodule

`default_nettype wire

// ===== hdl/ebml_element_header_encoder.sv =====
// ----------------------------------------------------------------------------
// EBML element header encoder
// Serializes one EBML element request into its bytes, last byte marked.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis: one request word per handshake; tuser carries the operation
//   (0 uint element, 1 data header, 2 master start of unknown size,
//   3 is accepted and produces nothing). m_axis: one byte per word,
//   most significant first, tlast on the final byte of a request.
//   With the shifter idle, an accepted request is written into the word queue
//   and its first byte then goes from the queue into the output register.
//   Throughput: one output byte per cycle while m_axis_tready is high; a request
//   of n bytes (2 to 13) holds the byte shifter until its last byte is out.
//   The front takes a new request every cycle while the word queue
//   (QueueDepth entries) has room; s_axis_tready drops when it is full.
//   A stalled m_axis holds its byte and stops the shifter; the queue
//   keeps accepting until full.
//   Reset empties the queue and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module ebml_element_header_encoder import ebmlenc_pkg::*; #(
	parameter int QueueDepth = QueueDepthDef
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               s_axis_tvalid,
	output logic                    s_axis_tready,
	// class_id[31:0], value[95:32], fixed_size[99:96], payload_length[155:100]
	input  wire logic [InDataW-1:0] s_axis_tdata,
	// operation[1:0]
	input  wire logic [OpW-1:0]     s_axis_tuser,
	output logic                    m_axis_tvalid,
	input  wire logic               m_axis_tready,
	// out_byte[7:0]
	output logic [ByteW-1:0]        m_axis_tdata,
	output logic                    m_axis_tlast
);

	desc_t      f_desc;
	desc_t      q_head;
	logic       f_push;
	logic       q_full;
	logic       q_empty;
	logic       b_pop;
	back_stat_t b_stat;
	logic [$clog2(QueueDepth+1)-1:0] q_count;

	ebmlenc_front u_front (
		.operation      (s_axis_tuser),
		.class_id       (s_axis_tdata[31:0]),
		.value          (s_axis_tdata[95:32]),
		.fixed_size     (s_axis_tdata[99:96]),
		.payload_length (s_axis_tdata[155:100]),
		.in_valid       (s_axis_tvalid),
		.in_ready       (s_axis_tready),
		.q_full         (q_full),
		.push           (f_push),
		.desc           (f_desc)
	);

	ebmlenc_queue #(.Depth(QueueDepth)) u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (f_push),
		.push_desc (f_desc),
		.full      (q_full),
		.pop       (b_pop),
		.empty     (q_empty),
		.head      (q_head),
		.count     (q_count)
	);

	ebmlenc_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.head      (q_head),
		.pop       (b_pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_byte  (m_axis_tdata),
		.out_last  (m_axis_tlast),
		.stat      (b_stat)
	);

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		q_count <= ($clog2(QueueDepth+1))'(QueueDepth))
		else $error("queue count above depth");

	a_busy_valid: assert property (@(posedge clk) disable iff (!arst_n)
		b_stat.rem != '0 |-> m_axis_tvalid)
		else $error("bytes pending without valid output");

	a_last_done: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tlast |-> b_stat.rem == '0)
		else $error("last byte shown with bytes pending");

	a_full_ready: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !s_axis_tready && !f_push)
		else $error("request taken while queue full");

endmodule

`default_nettype wire

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// EBML element header encoder testbench
// Drives element requests on s_axis with random gaps and predicts each
// request's byte sequence. It checks every m_axis word and its tlast
// against the prediction, in order. The receiver stalls at random and
// once holds off for a long stretch.
// ----------------------------------------------------------------------------

module testbench;
	import ebmlenc_pkg::*;

	localparam logic [63:0] UNKNOWN_SIZE = 64'h01FF_FFFF_FFFF_FFFF;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_byte;
	} enc_byte_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [InDataW-1:0] s_axis_tdata = '0;
	logic [OpW-1:0]     s_axis_tuser = '0;
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [ByteW-1:0]   m_axis_tdata;
	logic               m_axis_tlast;

	enc_byte_t expected_bytes[$];
	int        error_count = 0;
	int        bytes_checked = 0;
	int        op_count[4] = '{0, 0, 0, 0};
	int        input_stall_cycles = 0;
	int        src_idle_pct = 30;
	int        sink_idle_pct = 30;
	int        hold_request = 0;
	int        hold_left = 0;
	int        sink_stall_left = 0;

	ebml_element_header_encoder uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	initial begin
		#1_000_000;
		$display("Test completed with failures");
		$finish;
	end

	function automatic int pick_gap(int pct);
		if (pct == 0 || $urandom_range(0, 99) >= pct) return 0;
		if ($urandom_range(0, 9) == 0) return $urandom_range(8, 30);
		return $urandom_range(1, 3);
	endfunction

	function automatic void append_be(logic [63:0] v, int len);
		enc_byte_t b;
		for (int i = len - 1; i >= 0; i--) begin
			b.out_byte  = v[8*i +: 8];
			b.last_byte = 1'b0;
			expected_bytes.insert(expected_bytes.size(), b);
		end
	endfunction

	// byte sequence of one request, most significant byte first
	function automatic void predict_element(op_t op, logic [31:0] cid, logic [63:0] val,
			logic [3:0] fsz, logic [55:0] plen);
		int          id_len;
		int          sz;
		logic [63:0] coded;
		if (op == OP_NONE) return;
		id_len = 1;
		for (int i = 1; i < 4; i++)
			if ((cid >> (8 * i)) != 0) id_len = i + 1;
		append_be(64'(cid), id_len);
		case (op)
			OP_UINT: begin
				sz = int'(fsz);
				if (sz == 0) begin
					sz = 1;
					while (sz < 8 && (val >> (8 * sz)) != 0) sz++;
				end
				if (sz > 8) sz = 8;
				append_be(64'(8'h80 | 8'(sz)), 1);
				append_be(val, sz);
			end
			OP_DATA: begin
				sz = 1;
				while (sz < 8 && (64'(plen) >> (7 * sz)) != 0) sz++;
				coded = (64'(plen) & ((64'd1 << (7 * sz)) - 64'd1)) | (64'd1 << (7 * sz));
				append_be(coded, sz);
			end
			default: append_be(UNKNOWN_SIZE, 8);
		endcase
		expected_bytes[expected_bytes.size() - 1].last_byte = 1'b1;
	endfunction

	// called at a rising edge; returns at the edge where the word is taken
	task automatic send_request(op_t op, logic [31:0] cid, logic [63:0] val,
			logic [3:0] fsz, logic [55:0] plen);
		int gap;
		gap = pick_gap(src_idle_pct);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tdata  <= {4'h0, plen, fsz, val, cid};
		s_axis_tuser  <= op;
		s_axis_tvalid <= 1'b1;
		do begin
			@(posedge clk);
			if (!s_axis_tready) input_stall_cycles++;
		end while (!s_axis_tready);
		predict_element(op, cid, val, fsz, plen);
		op_count[op]++;
	endtask

	task automatic send_random_request();
		op_t         op;
		logic [31:0] cid;
		logic [63:0] val;
		logic [3:0]  fsz;
		logic [55:0] plen;
		int          r;
		int          k;
		r = $urandom_range(0, 19);
		op = (r < 8) ? OP_UINT : (r < 14) ? OP_DATA : (r < 18) ? OP_MASTER : OP_NONE;
		cid = $urandom;
		if ($urandom_range(0, 3) != 0) cid = cid >> (8 * $urandom_range(0, 3));
		val = {$urandom, $urandom};
		if ($urandom_range(0, 3) != 0) val = val >> (8 * $urandom_range(0, 7));
		fsz = ($urandom_range(0, 1) == 0) ? 4'd0 : 4'($urandom_range(1, 15));
		plen = 56'({$urandom, $urandom});
		r = $urandom_range(0, 9);
		if (r < 6) begin
			plen = plen >> (7 * $urandom_range(0, 7));
		end else if (r < 9) begin
			k = $urandom_range(1, 7);
			plen = (56'd1 << (7 * k)) - 56'($urandom_range(0, 1));
		end
		send_request(op, cid, val, fsz, plen);
	endtask

	task automatic wait_drained();
		while (expected_bytes.size() != 0) @(posedge clk);
	endtask

	task automatic test_directed();
		send_request(OP_UINT, 32'h0, 64'h0, 4'd0, 56'h0);
		send_request(OP_UINT, 32'hFFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 4'd0, '1);
		send_request(OP_UINT, 32'h4286, 64'h1, 4'd8, 56'h0);
		send_request(OP_UINT, 32'h2AD7B1, 64'h0123_4567_89AB_CDEF, 4'd1, 56'h0);
		send_request(OP_UINT, 32'h80, 64'h0123_4567_89AB_CDEF, 4'd3, 56'h0);
		send_request(OP_UINT, 32'h1A45_DFA3, 64'hDEAD_BEEF, 4'd15, 56'h0);
		send_request(OP_UINT, 32'hD7, 64'h100, 4'd9, 56'h0);
		send_request(OP_UINT, 32'h83, 64'h80_0000_0000_0000, 4'd0, 56'h0);
		send_request(OP_DATA, 32'hA3, 64'h0, 4'd0, 56'd0);
		send_request(OP_DATA, 32'hA3, 64'h0, 4'd0, 56'd127);
		send_request(OP_DATA, 32'hA3, 64'h0, 4'd0, 56'd128);
		send_request(OP_DATA, 32'h63A2, 64'h0, 4'd0, (56'd1 << 14) - 56'd1);
		send_request(OP_DATA, 32'h63A2, 64'h0, 4'd0, 56'd1 << 14);
		send_request(OP_DATA, 32'h0, '1, 4'hF, (56'd1 << 49) - 56'd1);
		send_request(OP_DATA, 32'hFFFF_FFFF, '1, 4'hF, 56'd1 << 49);
		send_request(OP_DATA, 32'h1654_AE6B, 64'h0, 4'd0, '1);
		send_request(OP_MASTER, 32'h1853_8067, 64'h0, 4'd0, 56'h0);
		send_request(OP_MASTER, 32'h1F43_B675, '1, 4'hF, '1);
		send_request(OP_MASTER, 32'h0, 64'h0, 4'd0, 56'h0);
		send_request(OP_MASTER, 32'hAE, 64'h0, 4'd0, 56'h0);
		send_request(OP_NONE, 32'hFFFF_FFFF, '1, 4'hF, '1);
		send_request(OP_UINT, 32'hE7, 64'hFF, 4'd0, 56'h0);
		send_request(OP_NONE, 32'h0, 64'h0, 4'd0, 56'h0);
		send_request(OP_UINT, 32'h4254, 64'h0, 4'd2, 56'h0);
	endtask

	task automatic test_random_mix();
		for (int i = 0; i < 70; i++) send_random_request();
	endtask

	// long receiver hold-off while requests keep coming back to back
	task automatic test_backpressure();
		src_idle_pct = 0;
		hold_request = 300;
		for (int i = 0; i < 25; i++) send_random_request();
		src_idle_pct = 30;
	endtask

	// sender waits for the pipe to empty, then a stretch with no idling
	task automatic test_drain_then_burst();
		s_axis_tvalid <= 1'b0;
		wait_drained();
		src_idle_pct = 0;
		sink_idle_pct = 0;
		for (int i = 0; i < 40; i++) send_random_request();
		src_idle_pct = 30;
		sink_idle_pct = 30;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (expected_bytes.size() == 0) begin
					$error("unexpected word: out_byte %02h last_byte %0b",
						m_axis_tdata, m_axis_tlast);
					error_count++;
				end else begin
					if (m_axis_tdata !== expected_bytes[0].out_byte) begin
						$error("out_byte mismatch: expected %02h, actual %02h",
							expected_bytes[0].out_byte, m_axis_tdata);
						error_count++;
					end
					if (m_axis_tlast !== expected_bytes[0].last_byte) begin
						$error("last_byte mismatch: expected %0b, actual %0b",
							expected_bytes[0].last_byte, m_axis_tlast);
						error_count++;
					end
					void'(expected_bytes.pop_front());
					bytes_checked++;
				end
			end
			if (hold_request > 0) begin
				hold_left = hold_request;
				hold_request = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_axis_tready <= 1'b0;
			end else if (sink_stall_left > 0) begin
				sink_stall_left--;
				m_axis_tready <= 1'b0;
			end else begin
				sink_stall_left = pick_gap(sink_idle_pct);
				m_axis_tready <= (sink_stall_left == 0);
				if (sink_stall_left > 0) sink_stall_left--;
			end
		end
	end

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);
		test_directed();
		test_random_mix();
		test_backpressure();
		test_drain_then_burst();
		test_random_mix();
		s_axis_tvalid <= 1'b0;
		wait_drained();
		repeat (20) @(posedge clk);
		$display("Summary: %0d requests (%0d uint, %0d data, %0d master, %0d unused op),",
			op_count[0] + op_count[1] + op_count[2] + op_count[3],
			op_count[0], op_count[1], op_count[2], op_count[3]);
		$display("Summary: %0d output words checked, input held off %0d cycles",
			bytes_checked, input_stall_cycles);
		if (error_count == 0 && expected_bytes.size() == 0) begin
			$display("Test completed successfully");
		end else begin
			$display("Test completed with failures");
		end
		$finish;
	end

endmodule
